>>> sv/edsim_pkg.sv
// ----------------------------------------------------------------------------
// edsim_pkg
// Shared types and constants for the edit distance similarity unit.
// ----------------------------------------------------------------------------
`default_nettype none

package edsim_pkg;

    localparam int SYM_W     = 8;
    localparam int MODE_W    = 2;
    localparam int DIST_W    = 5;
    localparam int FRAC_BITS = 16;
    localparam int SIM_W     = FRAC_BITS + 1;
    localparam int STEP_W    = 5;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND_A = 2'd0,
        MODE_APPEND_B = 2'd1,
        MODE_COMPUTE  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_ROW,
        ST_DRAIN,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic issue;
        logic next_row;
        logic div_init;
        logic div_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic last_col;
        logic last_row;
        logic div_last;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

>>> sv/edsim_ram.sv
// ----------------------------------------------------------------------------
// edsim_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module edsim_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/edsim_ctrl.sv
// ----------------------------------------------------------------------------
// edsim_ctrl
// Sequencer: input handshake, row/column walk, divider steps and result issue.
// ----------------------------------------------------------------------------
`default_nettype none

module edsim_ctrl (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic [edsim_pkg::MODE_W-1:0]           mode,
    output logic                                        in_stall,
    input  wire edsim_pkg::status_t                     st,
    output edsim_pkg::cmd_t                             cmd
);

    edsim_pkg::state_t state_reg;
    edsim_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= edsim_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            edsim_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    unique case (edsim_pkg::mode_t'(mode))
                        edsim_pkg::MODE_APPEND_A: cmd.load_a = 1'b1;
                        edsim_pkg::MODE_APPEND_B: cmd.load_b = 1'b1;
                        edsim_pkg::MODE_COMPUTE:
                        begin
                            cmd.start  = 1'b1;
                            state_next = st.empty ? edsim_pkg::ST_PREP
                                                  : edsim_pkg::ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end
            edsim_pkg::ST_FETCH:
            begin
                state_next = edsim_pkg::ST_ROW;
            end
            edsim_pkg::ST_ROW:
            begin
                cmd.issue = 1'b1;
                if (st.last_col)
                begin
                    if (st.last_row)
                    begin
                        state_next = edsim_pkg::ST_DRAIN;
                    end
                    else
                    begin
                        cmd.next_row = 1'b1;
                        state_next   = edsim_pkg::ST_FETCH;
                    end
                end
            end
            edsim_pkg::ST_DRAIN:
            begin
                state_next = edsim_pkg::ST_PREP;
            end
            edsim_pkg::ST_PREP:
            begin
                cmd.div_init = 1'b1;
                state_next   = edsim_pkg::ST_DIV;
            end
            edsim_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = edsim_pkg::ST_DONE;
                end
            end
            edsim_pkg::ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = edsim_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = edsim_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/edsim_datapath.sv
// ----------------------------------------------------------------------------
// edsim_datapath
// String stores, cost row cell unit, bit-serial divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module edsim_datapath #(
    parameter int MAX_LEN = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [edsim_pkg::SYM_W-1:0]            symbol,
    input  wire edsim_pkg::cmd_t                        cmd,
    output edsim_pkg::status_t                          st,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic      [edsim_pkg::DIST_W-1:0]           edit_distance,
    output logic      [edsim_pkg::SIM_W-1:0]            similarity_q16,
    output logic                                        either_empty,
    output logic                                        overflow
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int TW = $clog2(2 * MAX_LEN + 1);
    localparam int RW = TW + 1;
    localparam int SW = edsim_pkg::SIM_W;
    localparam int DW = edsim_pkg::DIST_W;

    // string lengths and flags
    logic [LW-1:0] la_reg, la_next;
    logic [LW-1:0] lb_reg, lb_next;
    logic          drop_reg, drop_next;

    // walk counters
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;

    // cell stage
    logic          pipe_v_reg, pipe_v_next;
    logic [LW-1:0] pipe_i_reg, pipe_i_next;
    logic [LW-1:0] pipe_j_reg, pipe_j_next;
    logic [LW-1:0] left_reg, left_next;
    logic [LW-1:0] diag_reg, diag_next;
    logic [LW-1:0] d_reg, d_next;
    logic          empty_reg, empty_next;

    // divider
    logic [RW-1:0]                 rem_reg, rem_next;
    logic [SW-1:0]                 q_reg, q_next;
    logic [edsim_pkg::STEP_W-1:0]  cnt_reg, cnt_next;

    // result register
    logic                          out_valid_reg, out_valid_next;
    logic [DW-1:0]                 dist_out_reg, dist_out_next;
    logic [SW-1:0]                 sim_out_reg, sim_out_next;
    logic                          empty_out_reg, empty_out_next;
    logic                          ovf_out_reg, ovf_out_next;

    // memories
    logic                          a_we, b_we, c_we;
    logic [AW-1:0]                 a_raddr, b_raddr, c_raddr, c_waddr;
    logic [edsim_pkg::SYM_W-1:0]   a_rdata, b_rdata;
    logic [LW-1:0]                 c_rdata;
    logic [LW-1:0]                 i_m1, j_m1, pj_m1;

    // cell arithmetic
    logic [LW-1:0] above, left_v, diag_v, cell_cost;
    logic [LW:0]   ins_c, del_c, sub_c, m1, m2;

    logic [TW-1:0] total;
    logic          ge;
    logic [RW-1:0] rem_sub;
    logic [DW+LW-1:0] d_ext;
    logic          a_full, b_full;

    assign a_full = (la_reg == LW'(MAX_LEN));
    assign b_full = (lb_reg == LW'(MAX_LEN));
    assign a_we   = cmd.load_a && !a_full;
    assign b_we   = cmd.load_b && !b_full;

    assign i_m1    = i_reg - LW'(1);
    assign j_m1    = j_reg - LW'(1);
    assign pj_m1   = pipe_j_reg - LW'(1);
    assign a_raddr = i_m1[AW-1:0];
    assign b_raddr = j_m1[AW-1:0];
    assign c_raddr = j_m1[AW-1:0];
    assign c_waddr = pj_m1[AW-1:0];
    assign c_we    = pipe_v_reg;

    edsim_ram #(.WIDTH(edsim_pkg::SYM_W), .DEPTH(MAX_LEN)) u_a_ram (
        .clk   (clk),
        .we    (a_we),
        .waddr (la_reg[AW-1:0]),
        .wdata (symbol),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    edsim_ram #(.WIDTH(edsim_pkg::SYM_W), .DEPTH(MAX_LEN)) u_b_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (lb_reg[AW-1:0]),
        .wdata (symbol),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    edsim_ram #(.WIDTH(LW), .DEPTH(MAX_LEN)) u_cost_ram (
        .clk   (clk),
        .we    (c_we),
        .waddr (c_waddr),
        .wdata (cell_cost),
        .raddr (c_raddr),
        .rdata (c_rdata)
    );

    // one cell of the distance table; first row and first column come from indices
    always_comb
    begin
        above     = (pipe_i_reg == LW'(1)) ? pipe_j_reg : c_rdata;
        left_v    = (pipe_j_reg == LW'(1)) ? pipe_i_reg : left_reg;
        diag_v    = (pipe_j_reg == LW'(1)) ? (pipe_i_reg - LW'(1)) : diag_reg;
        ins_c     = {1'b0, above} + (LW+1)'(1);
        del_c     = {1'b0, left_v} + (LW+1)'(1);
        sub_c     = {1'b0, diag_v} + (LW+1)'(a_rdata != b_rdata);
        m1        = (ins_c < del_c) ? ins_c : del_c;
        m2        = (m1 < sub_c) ? m1 : sub_c;
        cell_cost = m2[LW-1:0];
    end

    assign total   = TW'(la_reg) + TW'(lb_reg);
    assign ge      = (rem_reg >= RW'(total));
    assign rem_sub = ge ? (rem_reg - RW'(total)) : rem_reg;
    assign d_ext   = {{DW{1'b0}}, d_reg};

    assign st.empty    = (la_reg == '0) || (lb_reg == '0);
    assign st.last_col = (j_reg == lb_reg);
    assign st.last_row = (i_reg == la_reg);
    assign st.div_last = (cnt_reg == edsim_pkg::STEP_W'(SW - 1));
    assign st.out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        la_next        = la_reg;
        lb_next        = lb_reg;
        drop_next      = drop_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pipe_v_next    = cmd.issue;
        pipe_i_next    = i_reg;
        pipe_j_next    = j_reg;
        left_next      = left_reg;
        diag_next      = diag_reg;
        d_next         = d_reg;
        empty_next     = empty_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        dist_out_next  = dist_out_reg;
        sim_out_next   = sim_out_reg;
        empty_out_next = empty_out_reg;
        ovf_out_next   = ovf_out_reg;

        if (cmd.load_a)
        begin
            if (a_full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                la_next = la_reg + LW'(1);
            end
        end
        if (cmd.load_b)
        begin
            if (b_full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                lb_next = lb_reg + LW'(1);
            end
        end

        if (cmd.start)
        begin
            i_next     = LW'(1);
            j_next     = LW'(1);
            empty_next = st.empty;
            // an empty string leaves the other length as the distance
            d_next     = (la_reg == '0) ? lb_reg : la_reg;
        end
        if (cmd.issue)
        begin
            j_next = j_reg + LW'(1);
        end
        if (cmd.next_row)
        begin
            i_next = i_reg + LW'(1);
            j_next = LW'(1);
        end

        if (pipe_v_reg)
        begin
            left_next = cell_cost;
            diag_next = above;
            d_next    = cell_cost;
        end

        if (cmd.div_init)
        begin
            rem_next = RW'(total) - RW'(d_reg);
            q_next   = '0;
            cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next = {rem_sub[RW-2:0], 1'b0};
            q_next   = {q_reg[SW-2:0], ge};
            cnt_next = cnt_reg + edsim_pkg::STEP_W'(1);
        end

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
            dist_out_next  = d_ext[DW-1:0];
            sim_out_next   = empty_reg ? '0 : q_reg;
            empty_out_next = empty_reg;
            ovf_out_next   = drop_reg;
            la_next        = '0;
            lb_next        = '0;
            drop_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            la_reg        <= '0;
            lb_reg        <= '0;
            drop_reg      <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            pipe_v_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            la_reg        <= la_next;
            lb_reg        <= lb_next;
            drop_reg      <= drop_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            pipe_v_reg    <= pipe_v_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pipe_i_reg    <= pipe_i_next;
        pipe_j_reg    <= pipe_j_next;
        left_reg      <= left_next;
        diag_reg      <= diag_next;
        d_reg         <= d_next;
        empty_reg     <= empty_next;
        rem_reg       <= rem_next;
        q_reg         <= q_next;
        dist_out_reg  <= dist_out_next;
        sim_out_reg   <= sim_out_next;
        empty_out_reg <= empty_out_next;
        ovf_out_reg   <= ovf_out_next;
    end

    assign out_valid      = out_valid_reg;
    assign edit_distance  = dist_out_reg;
    assign similarity_q16 = sim_out_reg;
    assign either_empty   = empty_out_reg;
    assign overflow       = ovf_out_reg;

endmodule

`default_nettype wire

>>> sv/edit_distance_similarity_unit.sv
// ----------------------------------------------------------------------------
// edit_distance_similarity_unit
// Levenshtein distance and similarity ratio over two loaded byte strings.
// ----------------------------------------------------------------------------
// Each append beat (mode 0 to the first string, mode 1 to the second) adds
// one byte; a string already holding MAX_LEN characters drops the byte and
// raises overflow on the next result. A compute beat walks the distance table
// one cell per cycle through a single cell unit and the cost row memory,
// with a fetch state before each row for that row's character, then runs a
// bit-serial divider, one quotient bit per cycle, for the Q1.16 similarity.
// Appends are taken while a result waits at the output; a compute is taken
// too, and its result is held until the slot frees. A compute clears both
// lengths and the overflow flag. String bytes and the cost row sit in
// uninitialised RAM and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module edit_distance_similarity_unit #(
    parameter int MAX_LEN = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [edsim_pkg::MODE_W-1:0]           mode,
    input  wire logic [edsim_pkg::SYM_W-1:0]            symbol,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic      [edsim_pkg::DIST_W-1:0]           edit_distance,
    output logic      [edsim_pkg::SIM_W-1:0]            similarity_q16,
    output logic                                        either_empty,
    output logic                                        overflow
);

    edsim_pkg::cmd_t    cmd;
    edsim_pkg::status_t st;

    edsim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .st       (st),
        .cmd      (cmd)
    );

    edsim_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .symbol         (symbol),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .edit_distance  (edit_distance),
        .similarity_q16 (similarity_q16),
        .either_empty   (either_empty),
        .overflow       (overflow)
    );

endmodule

`default_nettype wire

>>> sv/edsim_checker.sv
// ----------------------------------------------------------------------------
// edsim_checker
// Port-level checks on the edit distance similarity unit.
// ----------------------------------------------------------------------------
`default_nettype none

module edsim_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_stall,
    input  wire logic [edsim_pkg::MODE_W-1:0]           mode,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_stall,
    input  wire logic [edsim_pkg::DIST_W-1:0]           edit_distance,
    input  wire logic [edsim_pkg::SIM_W-1:0]            similarity_q16,
    input  wire logic                                   either_empty,
    input  wire logic                                   overflow
);

    localparam logic [edsim_pkg::SIM_W-1:0] SIM_ONE = edsim_pkg::SIM_W'(1 << 16);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(edit_distance) && $stable(similarity_q16)
            && $stable(either_empty) && $stable(overflow))
        else $error("result beat changed while stalled");

    // empty string gives zero similarity
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && either_empty |-> similarity_q16 == '0)
        else $error("similarity not zero for an empty string");

    // two non-empty strings always share a nonzero, bounded ratio
    a_sim_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !either_empty |->
            similarity_q16 != '0 && similarity_q16 <= SIM_ONE)
        else $error("similarity out of range");

    // a ratio of one only for identical strings
    a_sim_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && similarity_q16 == SIM_ONE |-> edit_distance == '0)
        else $error("full similarity with nonzero distance");

    // a compute beat keeps the input closed on the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && mode == edsim_pkg::MODE_COMPUTE |=> in_stall)
        else $error("input open straight after a compute beat");

endmodule

bind edit_distance_similarity_unit edsim_checker u_edsim_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edit_distance  (edit_distance),
    .similarity_q16 (similarity_q16),
    .either_empty   (either_empty),
    .overflow       (overflow)
);

`default_nettype wire

>>> tb/sv/tb_edit_distance_similarity_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_edit_distance_similarity_unit
// Loads string pairs into the similarity unit, runs computes and checks each
// result beat against a behavioural edit distance and ratio predictor.
// ----------------------------------------------------------------------------
module tb_edit_distance_similarity_unit;

    localparam int STR_MAX = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = 320;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam logic [edsim_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [edsim_pkg::DIST_W-1:0] distance;
        logic [edsim_pkg::SIM_W-1:0]  sim;
        logic                         empty;
        logic                         ovf;
    } similarity_result_t;

    class similarity_scoreboard;
        logic [edsim_pkg::SYM_W-1:0] first_str [STR_MAX];
        logic [edsim_pkg::SYM_W-1:0] second_str [STR_MAX];
        int first_len;
        int second_len;
        bit dropped;
        similarity_result_t expected_q [$];
        int failures;
        int computes_noted;
        int results_checked;

        function new();
            first_len = 0;
            second_len = 0;
            dropped = 0;
            failures = 0;
            computes_noted = 0;
            results_checked = 0;
        endfunction

        function int levenshtein_cost();
            int row [STR_MAX + 1];
            int diag;
            int above;
            int sub;
            int best;
            for (int j = 0; j <= second_len; j++)
                row[j] = j;
            for (int i = 1; i <= first_len; i++)
            begin
                diag = row[0];
                row[0] = i;
                for (int j = 1; j <= second_len; j++)
                begin
                    above = row[j];
                    sub = diag + ((first_str[i-1] == second_str[j-1]) ? 0 : 1);
                    best = above + 1;
                    if (row[j-1] + 1 < best)
                        best = row[j-1] + 1;
                    if (sub < best)
                        best = sub;
                    row[j] = best;
                    diag = above;
                end
            end
            return row[second_len];
        endfunction

        function void note_beat(logic [edsim_pkg::MODE_W-1:0] m,
                                logic [edsim_pkg::SYM_W-1:0] s);
            similarity_result_t exp_res;
            int d;
            int total;
            longint num;
            if (m == edsim_pkg::MODE_APPEND_A)
            begin
                if (first_len < STR_MAX)
                begin
                    first_str[first_len] = s;
                    first_len++;
                end
                else
                    dropped = 1;
            end
            else if (m == edsim_pkg::MODE_APPEND_B)
            begin
                if (second_len < STR_MAX)
                begin
                    second_str[second_len] = s;
                    second_len++;
                end
                else
                    dropped = 1;
            end
            else if (m == edsim_pkg::MODE_COMPUTE)
            begin
                d = levenshtein_cost();
                total = first_len + second_len;
                exp_res.distance = d[edsim_pkg::DIST_W-1:0];
                exp_res.empty = (first_len == 0 || second_len == 0);
                exp_res.ovf = dropped;
                exp_res.sim = '0;
                if (!exp_res.empty)
                begin
                    num = longint'(total - d) << edsim_pkg::FRAC_BITS;
                    num = num / total;
                    exp_res.sim = num[edsim_pkg::SIM_W-1:0];
                end
                expected_q = {expected_q, exp_res};
                computes_noted++;
                first_len = 0;
                second_len = 0;
                dropped = 0;
            end
        endfunction

        function void check_result(similarity_result_t got);
            similarity_result_t exp_res;
            results_checked++;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result beat: distance=%0d sim=%0d empty=%0b ovf=%0b",
                             got.distance, got.sim, got.empty, got.ovf);
                return;
            end
            exp_res = expected_q.pop_front();
            if (got !== exp_res)
            begin
                failures++;
                if (failures <= 10)
                begin
                    $display("mismatch on result %0d: exp distance=%0d sim=%0d empty=%0b ovf=%0b",
                             results_checked, exp_res.distance, exp_res.sim,
                             exp_res.empty, exp_res.ovf);
                    $display("    got distance=%0d sim=%0d empty=%0b ovf=%0b",
                             got.distance, got.sim, got.empty, got.ovf);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [edsim_pkg::MODE_W-1:0] mode;
    logic [edsim_pkg::SYM_W-1:0] symbol;
    logic out_valid;
    logic out_stall;
    logic [edsim_pkg::DIST_W-1:0] edit_distance;
    logic [edsim_pkg::SIM_W-1:0] similarity_q16;
    logic either_empty;
    logic overflow;

    similarity_scoreboard sb;
    bit quiet;
    int items_sent;
    int cycle_count;

    edit_distance_similarity_unit #(
        .MAX_LEN(STR_MAX)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .mode(mode),
        .symbol(symbol),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .edit_distance(edit_distance),
        .similarity_q16(similarity_q16),
        .either_empty(either_empty),
        .overflow(overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // one beat, held until the block takes it
    task automatic send_beat(logic [edsim_pkg::MODE_W-1:0] m,
                             logic [edsim_pkg::SYM_W-1:0] s);
        in_valid <= 1'b1;
        mode <= m;
        symbol <= s;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_beat(m, s);
        if (m != MODE_UNUSED)
            items_sent++;
    endtask

    task automatic maybe_gap();
        if (!quiet && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic send_random_pair();
        logic [edsim_pkg::SYM_W-1:0] alpha [3];
        logic [edsim_pkg::SYM_W-1:0] a_str [20];
        logic [edsim_pkg::SYM_W-1:0] b_str [20];
        int la;
        int lb;
        int ia;
        int ib;
        int pick;
        int k;
        bit narrow;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            la = $urandom_range(14, 19);
            lb = $urandom_range(14, 19);
        end
        else if (pick < 4)
        begin
            la = $urandom_range(0, 16);
            lb = $urandom_range(0, 16);
        end
        else
        begin
            la = $urandom_range(0, 6);
            lb = $urandom_range(0, 6);
        end
        narrow = $urandom_range(0, 1);
        for (k = 0; k < 3; k++)
            alpha[k] = edsim_pkg::SYM_W'($urandom);
        for (k = 0; k < 20; k++)
        begin
            a_str[k] = narrow ? alpha[$urandom_range(0, 2)] : edsim_pkg::SYM_W'($urandom);
            b_str[k] = narrow ? alpha[$urandom_range(0, 2)] : edsim_pkg::SYM_W'($urandom);
        end
        // near copy: second string differs from the first in at most one place
        if ($urandom_range(0, 3) == 0)
        begin
            lb = la;
            for (k = 0; k < 20; k++)
                b_str[k] = a_str[k];
            if (lb > 0)
                b_str[$urandom_range(0, lb - 1)] = edsim_pkg::SYM_W'($urandom);
        end
        ia = 0;
        ib = 0;
        while (ia < la || ib < lb)
        begin
            if (ib >= lb || (ia < la && $urandom_range(0, 1) == 1))
            begin
                send_beat(edsim_pkg::MODE_APPEND_A, a_str[ia]);
                ia++;
            end
            else
            begin
                send_beat(edsim_pkg::MODE_APPEND_B, b_str[ib]);
                ib++;
            end
            if ($urandom_range(0, 29) == 0)
                send_beat(MODE_UNUSED, edsim_pkg::SYM_W'($urandom));
            maybe_gap();
        end
        send_beat(edsim_pkg::MODE_COMPUTE, edsim_pkg::SYM_W'($urandom));
        maybe_gap();
    endtask

    // result side: random stall bursts plus one long hold-off
    initial
    begin
        int stall_left;
        bit held_off;
        similarity_result_t got;
        out_stall = 1'b0;
        stall_left = 0;
        held_off = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got.distance = edit_distance;
                got.sim = similarity_q16;
                got.empty = either_empty;
                got.ovf = overflow;
                sb.check_result(got);
            end
            if (!held_off && sb.results_checked >= 3)
            begin
                held_off = 1;
                stall_left = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int k;
        sb = new();
        quiet = 0;
        items_sent = 0;
        in_valid = 1'b0;
        mode = edsim_pkg::MODE_APPEND_A;
        symbol = '0;
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // both strings empty
        send_beat(edsim_pkg::MODE_COMPUTE, 8'h00);
        maybe_gap();
        // second string empty, symbol extremes
        send_beat(edsim_pkg::MODE_APPEND_A, 8'h00);
        send_beat(edsim_pkg::MODE_APPEND_A, 8'hFF);
        send_beat(edsim_pkg::MODE_COMPUTE, 8'hFF);
        // unused mode is ignored
        send_beat(MODE_UNUSED, 8'hA5);
        maybe_gap();
        // first string overfilled by one byte
        for (k = 0; k <= STR_MAX; k++)
        begin
            send_beat(edsim_pkg::MODE_APPEND_A, (k % 2 == 0) ? 8'h55 : 8'hAA);
            maybe_gap();
        end
        send_beat(edsim_pkg::MODE_APPEND_B, 8'hAA);
        send_beat(edsim_pkg::MODE_COMPUTE, 8'h00);
        maybe_gap();

        while (items_sent < 400 || sb.computes_noted < 40)
        begin
            if (items_sent >= 340)
                quiet = 1;
            send_random_pair();
        end
        in_valid <= 1'b0;
        quiet = 1;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
